/* hw/rtl/shuffled_park_miller_uniform_rng_unit_assert.svh */
// ----------------------------------------------------------------------------
// shuffled_park_miller_uniform_rng_unit_assert.svh
// assertion macros used by the checker of the generator block
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_PARK_MILLER_UNIFORM_RNG_UNIT_ASSERT_SVH
`define SHUFFLED_PARK_MILLER_UNIFORM_RNG_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPMU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SPMU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/spmu_pkg.sv */
// ----------------------------------------------------------------------------
// spmu_pkg
// constants and types of the shuffled minimal-standard uniform generator
// ----------------------------------------------------------------------------
package spmu_pkg;

  // generator constants
  localparam int unsigned VAL_W       = 31;
  localparam int unsigned MULT_W      = 15;
  localparam int unsigned PROD_W      = VAL_W + MULT_W;
  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [VAL_W-1:0]  LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  SAMPLE_MAX = 31'd2147483389;

  // shuffle table, depth a power of two so the slot is the top bits
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned INIT_STEPS  = TABLE_DEPTH + 8;
  localparam int unsigned CNT_W       = $clog2(INIT_STEPS);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_RED,
    ST_DRAW_MUL,
    ST_DRAW_WB
  } spmu_state_t;

endpackage

/* hw/rtl/shuffled_park_miller_uniform_rng_unit.sv */
// ----------------------------------------------------------------------------
// shuffled_park_miller_uniform_rng_unit
// Lehmer generator (x * 16807 mod 2^31-1) behind a Bays-Durham shuffle table
// ----------------------------------------------------------------------------
// Usage
//   cfg_valid/cfg_data write the 31-bit seed; always ready, takes effect at
//   the next warm-up (after reset, or on an item with restart set).
//   in_tdata bit 0 is restart; each accepted item yields one result item.
//   out_tdata[30:0] is the sample (fraction = sample / 2147483647),
//   out_tuser is set when the sample was saturated at 2147483389.
// Sequencing
//   a normal draw runs the modular multiply (multiply, then Mersenne fold)
//   and the table read, then the write-back of the same slot and the result
//   load. A new item is accepted in the cycle a result is loaded, so the
//   block does not take an item while one is still in flight.
//   A warm-up runs 40 generator steps (multiply, then fold) ahead of the
//   draw of the item that triggers it.
// Reset
//   clears the sequencer, output valid and sets the seed to 1; the table is
//   not cleared, the first item always runs the warm-up that fills it.
// Stall
//   a finished result waits in the output register; the next item is held
//   at its write-back step until out_tready frees that register.
// ----------------------------------------------------------------------------
module shuffled_park_miller_uniform_rng_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data,     // seed
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [0] restart, [7:1] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [30:0] sample, [31] zero
  output logic        out_tuser     // [0] clamped
);

  localparam int unsigned VW = spmu_pkg::VAL_W;
  localparam int unsigned AW = spmu_pkg::TBL_AW;
  localparam int unsigned CW = spmu_pkg::CNT_W;
  localparam int unsigned PW = spmu_pkg::PROD_W;

  // shuffle table
  logic [VW-1:0] tbl_mem [spmu_pkg::TABLE_DEPTH];

  spmu_pkg::spmu_state_t state_r, state_nxt;
  logic [VW-1:0] seed_r;
  logic [VW-1:0] x_r, x_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [VW-1:0] shuf_r, shuf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          init_pend_r, init_pend_nxt;
  logic [VW-1:0] rd_r;
  logic [VW-1:0] sample_r, sample_nxt;
  logic          clamped_r, clamped_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic [AW-1:0] slot;
  logic [VW:0]   fold_sum;
  logic [VW-1:0] red;
  logic [VW-1:0] start_val;
  logic [VW-1:0] shuf_after;
  logic          wb_fire;
  logic          in_acc;
  logic          need_init;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= VW'(1);
    end else if (cfg_valid) begin
      seed_r <= cfg_data;
    end
  end

  // mersenne fold of the registered product, one conditional subtract
  assign fold_sum = {1'b0, prod_r[VW-1:0]} + (VW+1)'(prod_r[PW-1:VW]);
  assign red = (fold_sum >= {1'b0, spmu_pkg::LCG_MOD})
             ? VW'(fold_sum - {1'b0, spmu_pkg::LCG_MOD})
             : fold_sum[VW-1:0];

  // warm-up start value: seed mod 2^31-1, zero taken as one
  assign start_val = (seed_r == '0 || seed_r == spmu_pkg::LCG_MOD) ? VW'(1) : seed_r;

  // slot is the shuffle output divided by 2^31 / depth
  assign slot = shuf_r[VW-1 -: AW];

  // handshake
  assign wb_fire    = (state_r == spmu_pkg::ST_DRAW_WB) && (!out_valid_r || out_tready);
  assign in_tready  = (state_r == spmu_pkg::ST_IDLE) || wb_fire;
  assign in_acc     = in_tvalid && in_tready;
  assign shuf_after = wb_fire ? rd_r : shuf_r;
  assign need_init  = in_tdata[0] || init_pend_r || (shuf_after == '0);

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    prod_nxt      = prod_r;
    shuf_nxt      = shuf_r;
    cnt_nxt       = cnt_r;
    init_pend_nxt = init_pend_r;
    sample_nxt    = sample_r;
    clamped_nxt   = clamped_r;
    out_valid_nxt = out_valid_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = slot;
    wr_data       = red;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      spmu_pkg::ST_IDLE: begin
      end
      spmu_pkg::ST_INIT_MUL: begin
        prod_nxt  = PW'(x_r) * PW'(spmu_pkg::LCG_MULT);
        state_nxt = spmu_pkg::ST_INIT_RED;
      end
      spmu_pkg::ST_INIT_RED: begin
        x_nxt   = red;
        wr_addr = cnt_r[AW-1:0];
        wr_en   = (cnt_r < CW'(spmu_pkg::TABLE_DEPTH));
        if (cnt_r == '0) begin
          shuf_nxt      = red;
          init_pend_nxt = 1'b0;
          state_nxt     = spmu_pkg::ST_DRAW_MUL;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = spmu_pkg::ST_INIT_MUL;
        end
      end
      spmu_pkg::ST_DRAW_MUL: begin
        prod_nxt  = PW'(x_r) * PW'(spmu_pkg::LCG_MULT);
        rd_en     = 1'b1;
        state_nxt = spmu_pkg::ST_DRAW_WB;
      end
      spmu_pkg::ST_DRAW_WB: begin
        if (wb_fire) begin
          x_nxt         = red;
          wr_en         = 1'b1;
          shuf_nxt      = rd_r;
          out_valid_nxt = 1'b1;
          // saturate at the top limit
          if (rd_r > spmu_pkg::SAMPLE_MAX) begin
            sample_nxt  = spmu_pkg::SAMPLE_MAX;
            clamped_nxt = 1'b1;
          end else begin
            sample_nxt  = rd_r;
            clamped_nxt = 1'b0;
          end
          state_nxt = spmu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spmu_pkg::ST_IDLE;
      end
    endcase

    // new item: warm up first, or go straight to a draw
    if (in_acc) begin
      if (need_init) begin
        x_nxt     = start_val;
        cnt_nxt   = CW'(spmu_pkg::INIT_STEPS - 1);
        state_nxt = spmu_pkg::ST_INIT_MUL;
      end else begin
        state_nxt = spmu_pkg::ST_DRAW_MUL;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spmu_pkg::ST_IDLE;
      init_pend_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_pend_r <= init_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    prod_r    <= prod_nxt;
    shuf_r    <= shuf_nxt;
    cnt_r     <= cnt_nxt;
    sample_r  <= sample_nxt;
    clamped_r <= clamped_nxt;
  end

  // table write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
  end

  // table read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= tbl_mem[slot];
    end
  end

  // outputs
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, sample_r};
  assign out_tuser  = clamped_r;

endmodule

/* hw/rtl/spmu_checker.sv */
// ----------------------------------------------------------------------------
// spmu_checker
// port-level checks of the shuffled uniform generator
// ----------------------------------------------------------------------------
`include "shuffled_park_miller_uniform_rng_unit_assert.svh"

module spmu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result keeps its value
  `SPMU_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // saturation flag only with the top limit
  `SPMU_ASSERT_NOW(a_clamp_val, clk, rst_n, out_tvalid && out_tuser, out_tdata[30:0] == spmu_pkg::SAMPLE_MAX, "clamped result not at the top limit")

  // sample range
  `SPMU_ASSERT_NOW(a_range, clk, rst_n, out_tvalid, out_tdata[30:0] != 31'd0 && out_tdata[30:0] <= spmu_pkg::SAMPLE_MAX && !out_tdata[31], "sample out of range")

  // no two items are accepted back to back
  `SPMU_ASSERT_NXT(a_rate, clk, rst_n, in_tvalid && in_tready, !in_tready, "item accepted in back-to-back cycles")

endmodule

bind shuffled_park_miller_uniform_rng_unit spmu_checker u_spmu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the shuffled minimal-standard uniform generator:
// seed writes and draw requests go in over their own channels, every result
// is compared against a behavioural Lehmer-plus-shuffle-table prediction
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 4000;   // cycles with no handshake at all
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int ITEMS_PER_PHASE = 175;

  // prediction and expected results of the generator
  class draw_scoreboard;
    typedef struct packed {
      logic [30:0] sample;
      logic        clamped;
    } draw_t;

    longint unsigned modulus;
    longint unsigned slot_div;
    logic [30:0]     seed_reg;
    logic [30:0]     lehmer;
    logic [30:0]     shuffle_out;
    logic [30:0]     shuffle_tbl [spmu_pkg::TABLE_DEPTH];
    bit              warmup_due;
    draw_t           expected_draws [$];
    int              errors;

    function new();
      modulus     = 64'(spmu_pkg::LCG_MOD);
      slot_div    = 64'd1 + (modulus - 64'd1) / spmu_pkg::TABLE_DEPTH;
      seed_reg    = 31'd1;
      lehmer      = 31'd1;
      shuffle_out = '0;
      foreach (shuffle_tbl[i]) shuffle_tbl[i] = '0;
      warmup_due  = 1'b1;
      errors      = 0;
    endfunction

    static function longint unsigned mulmod(longint unsigned a, longint unsigned b);
      return (a * b) % 64'(spmu_pkg::LCG_MOD);
    endfunction

    static function longint unsigned powmod(longint unsigned b, longint unsigned e);
      longint unsigned r;
      r = 64'd1;
      while (e != 0) begin
        if ((e & 64'd1) != 0) r = mulmod(r, b);
        b = mulmod(b, b);
        e = e >> 1;
      end
      return r;
    endfunction

    // seed whose first draw after a warm-up lands on a value above the
    // saturation limit: pick the slot value and step the generator backwards
    static function logic [30:0] find_clamping_seed();
      longint unsigned m, inv, v, div;
      int s;
      m   = 64'(spmu_pkg::LCG_MOD);
      div = 64'd1 + (m - 64'd1) / spmu_pkg::TABLE_DEPTH;
      inv = powmod(64'(spmu_pkg::LCG_MULT), m - 64'd2);
      for (v = m - 64'd1; v > 64'(spmu_pkg::SAMPLE_MAX); v--) begin
        for (s = 1; s < spmu_pkg::TABLE_DEPTH; s++) begin
          if (mulmod(v, powmod(64'(spmu_pkg::LCG_MULT), s)) / div == s)
            return 31'(mulmod(v, powmod(inv, spmu_pkg::INIT_STEPS - s)));
        end
      end
      return 31'd1;
    endfunction

    function logic [30:0] lehmer_step(logic [30:0] x);
      return 31'(mulmod(64'(x), 64'(spmu_pkg::LCG_MULT)));
    endfunction

    // 40 generator steps, the last TABLE_DEPTH of them fill the table
    function void warm_up();
      logic [30:0] x;
      int j;
      x = 31'(64'(seed_reg) % modulus);
      if (x == 0) x = 31'd1;
      for (j = spmu_pkg::INIT_STEPS - 1; j >= 0; j--) begin
        x = lehmer_step(x);
        if (j < spmu_pkg::TABLE_DEPTH) shuffle_tbl[j] = x;
      end
      lehmer      = x;
      shuffle_out = shuffle_tbl[0];
      warmup_due  = 1'b0;
    endfunction

    function void load_seed(logic [30:0] value);
      seed_reg = value;
    endfunction

    // one accepted request: predict its draw
    function void note_request(bit restart);
      longint unsigned slot;
      draw_t d;
      if (restart || warmup_due || shuffle_out == 0) warm_up();
      lehmer = lehmer_step(lehmer);
      slot   = 64'(shuffle_out) / slot_div;
      if (slot >= spmu_pkg::TABLE_DEPTH) slot = spmu_pkg::TABLE_DEPTH - 1;
      shuffle_out       = shuffle_tbl[slot];
      shuffle_tbl[slot] = lehmer;
      if (shuffle_out > spmu_pkg::SAMPLE_MAX) begin
        d.sample  = spmu_pkg::SAMPLE_MAX;
        d.clamped = 1'b1;
      end else begin
        d.sample  = shuffle_out;
        d.clamped = 1'b0;
      end
      expected_draws.push_back(d);
    endfunction

    function int pending();
      return expected_draws.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("draw mismatch: %s", what);
    endtask

    task check_draw(logic [30:0] sample, logic clamped);
      draw_t d;
      if (expected_draws.size() == 0) begin
        report($sformatf("unexpected result sample=%0d clamped=%0b", sample, clamped));
      end else begin
        d = expected_draws.pop_front();
        if (sample !== d.sample)
          report($sformatf("sample %0d, expected %0d", sample, d.sample));
        if (clamped !== d.clamped)
          report($sformatf("clamped %0b, expected %0b", clamped, d.clamped));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [0] restart, [7:1] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [30:0] sample, [31] zero
  logic        out_tuser;    // [0] clamped

  draw_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    hold_count;
  int             quiet_cycles;

  shuffled_park_miller_uniform_rng_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result ready: random stalls, or a long hold-off when one is requested
  initial begin
    int left;
    int unsigned seen;
    left = 0;
    seen = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_count != seen) begin
        seen = hold_count;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_draw(out_tdata[30:0], out_tuser);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // offer one draw request, with a random gap first
  task automatic request_draw(input bit restart);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, restart};
    do @(posedge clk); while (!in_tready);
    sb.note_request(restart);
  endtask

  // stop offering and wait for every outstanding draw
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // seed write, only with the block idle
  task automatic write_seed(input logic [30:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.load_seed(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int ph;
    int n;
    sb             = new();
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_count     = 0;
    quiet_cycles   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // warm-up deferred to the first request, using the seed written after reset
    write_seed(31'h2AAA_AAAA);
    request_draw(1'b0);
    request_draw(1'b0);
    request_draw(1'b0);
    // a seed write alone does not restart the sequence
    write_seed(31'h5555_5555);
    request_draw(1'b0);
    request_draw(1'b0);
    request_draw(1'b1);
    request_draw(1'b0);
    request_draw(1'b1);
    request_draw(1'b1);
    // zero seed, seed at the modulus, largest legal seed
    write_seed(31'd0);
    request_draw(1'b1);
    request_draw(1'b0);
    write_seed(spmu_pkg::LCG_MOD);
    request_draw(1'b1);
    request_draw(1'b0);
    write_seed(spmu_pkg::LCG_MOD - 31'd1);
    request_draw(1'b1);
    request_draw(1'b0);
    // first draw saturates at the top limit
    write_seed(draw_scoreboard::find_clamping_seed());
    request_draw(1'b1);
    request_draw(1'b0);
    request_draw(1'b0);
    write_seed(31'd1);
    request_draw(1'b1);
    request_draw(1'b0);

    // random phases with different idling on each side
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      write_seed(31'($urandom_range(32'h7FFF_FFFF)));
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 0 && n == 40) hold_count++;
        // sender pauses until the block is empty
        if (ph == 1 && n == 80) wait_drained();
        // fresh seed halfway through the later phases
        if (ph >= 2 && n == 90) write_seed(31'($urandom_range(32'h7FFF_FFFF)));
        request_draw($urandom_range(99) < 5);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/spmu_pkg.sv
hw/rtl/shuffled_park_miller_uniform_rng_unit.sv
hw/rtl/spmu_checker.sv
sim/tb_top.sv
